/* src/kesd_pkg.sv */
// Package for the caret and backslash escape decoder.
// Decoder modes, character codes and the state and result records.
// No dependencies.
package kesd_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_CARET  = 3'd1,
    MODE_BSLASH = 3'd2,
    MODE_HEX    = 3'd3,
    MODE_OCT    = 3'd4,
    MODE_SKIP   = 3'd5
  } mode_t;

  localparam logic [7:0] UNIT_LIMIT_RST = 8'd255;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_F   = 8'h46;
  localparam logic [7:0] CH_UC_X   = 8'h58;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_E   = 8'h65;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_X   = 8'h78;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] units_used;
    logic [7:0] bytes_out;
    logic [7:0] digit_value;
    logic [1:0] digits_left;
    logic       digits_stopped;
  } dec_state_t;

  localparam dec_state_t DEC_STATE_RST = '{
    mode:           MODE_NORMAL,
    units_used:     8'd0,
    bytes_out:      8'd0,
    digit_value:    8'd0,
    digits_left:    2'd0,
    digits_stopped: 1'b0
  };

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_end;
    logic [7:0] byte_count;
  } dec_result_t;

endpackage

/* src/key_escape_sequence_decoder.sv */
// Top level of the caret and backslash escape decoder.
// Input register, decode step (kesd_step) and result register; uses kesd_pkg.
//
//   channel  ports                                       width  dir
//   in       in_valid, in_stall, in_ch                   8      request in
//   out      out_valid, out_stall, out_byte,
//            out_is_end, out_byte_count                  8/1/8  request out
//   cfg      cfg_we, cfg_unit_limit                      8      write only
//
// One request per cycle sustained while the result is not stalled; path is
// the input register, then the decode step into the result register.
// Decoder state updates in the same cycle a request leaves the input register.
// Synchronous active-low reset clears state, valids and sets unit_limit to 255.
// A stalled result holds; the input register keeps taking requests while the
// result register is free or being drained.
module key_escape_sequence_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_is_end,
  output logic [7:0] out_byte_count,
  input  logic       cfg_we,
  input  logic [7:0] cfg_unit_limit
);

  logic                  ch_valid_r;
  logic [7:0]            ch_r;
  logic [7:0]            limit_r;
  kesd_pkg::dec_state_t  state_r;
  kesd_pkg::dec_state_t  state_nxt;
  logic                  res_valid;
  kesd_pkg::dec_result_t res;
  logic                  out_valid_r;
  kesd_pkg::dec_result_t out_r;
  logic                  adv;
  logic                  proc;

  assign adv      = !out_valid_r || !out_stall;
  assign proc     = ch_valid_r && adv;
  assign in_stall = ch_valid_r && !adv;

  kesd_step u_step (
    .ch         (ch_r),
    .unit_limit (limit_r),
    .st         (state_r),
    .st_nxt     (state_nxt),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= kesd_pkg::DEC_STATE_RST;
      limit_r     <= kesd_pkg::UNIT_LIMIT_RST;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_unit_limit;
      end
      if (!in_stall) begin
        ch_valid_r <= in_valid;
      end
      if (proc) begin
        state_r <= state_nxt;
      end
      if (adv) begin
        out_valid_r <= proc && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      ch_r <= in_ch;
    end
    if (proc && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_r.out_byte;
  assign out_is_end     = out_r.is_end;
  assign out_byte_count = out_r.byte_count;

endmodule

/* src/kesd_step.sv */
// Next-state and result logic for one character of the escape decoder.
// Purely combinational; uses kesd_pkg.
module kesd_step (
  input  logic [7:0]           ch,
  input  logic [7:0]           unit_limit,
  input  kesd_pkg::dec_state_t st,
  output kesd_pkg::dec_state_t st_nxt,
  output logic                 res_valid,
  output kesd_pkg::dec_result_t res
);

  logic       is_lower;
  logic       is_upper;
  logic       is_dec;
  logic       is_oct;
  logic       hex_ok;
  logic [3:0] hex_val;
  logic       dig_ok;
  logic [7:0] dig_acc;
  logic       start;

  assign is_lower = (ch >= kesd_pkg::CH_LC_A) && (ch <= kesd_pkg::CH_LC_Z);
  assign is_upper = (ch >= kesd_pkg::CH_UC_A) && (ch <= kesd_pkg::CH_UC_Z);
  assign is_dec   = (ch >= kesd_pkg::CH_0) && (ch <= kesd_pkg::CH_9);
  assign is_oct   = (ch >= kesd_pkg::CH_0) && (ch <= kesd_pkg::CH_7);

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (is_dec) begin
      hex_val = 4'(ch - kesd_pkg::CH_0);
    end else if ((ch >= kesd_pkg::CH_LC_A) && (ch <= kesd_pkg::CH_LC_F)) begin
      hex_val = 4'(ch - kesd_pkg::CH_LC_A + 8'd10);
    end else if ((ch >= kesd_pkg::CH_UC_A) && (ch <= kesd_pkg::CH_UC_F)) begin
      hex_val = 4'(ch - kesd_pkg::CH_UC_A + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    if (st.mode == kesd_pkg::MODE_HEX) begin
      dig_ok  = hex_ok;
      dig_acc = {st.digit_value[3:0], hex_val};
    end else begin
      dig_ok  = is_oct;
      dig_acc = {st.digit_value[4:0], ch[2:0]};
    end
  end

  always_comb begin
    st_nxt    = st;
    res_valid = 1'b0;
    res       = '0;
    start     = 1'b0;

    unique case (st.mode)
      kesd_pkg::MODE_CARET: begin
        if (ch == kesd_pkg::CH_NUL) begin
          res_valid = 1'b1;
          res       = '{out_byte: 8'd0, is_end: 1'b1, byte_count: st.bytes_out};
          st_nxt    = kesd_pkg::DEC_STATE_RST;
        end else if (is_lower || is_upper) begin
          res_valid        = 1'b1;
          res.out_byte     = is_lower ? (ch - kesd_pkg::CH_LC_A + 8'd1)
                                      : (ch - kesd_pkg::CH_UC_A + 8'd1);
          st_nxt.bytes_out = st.bytes_out + 8'd1;
          st_nxt.mode      = kesd_pkg::MODE_NORMAL;
        end else begin
          st_nxt.mode = kesd_pkg::MODE_NORMAL;
          start       = 1'b1;
        end
      end
      kesd_pkg::MODE_BSLASH: begin
        if (ch == kesd_pkg::CH_NUL) begin
          res_valid = 1'b1;
          res       = '{out_byte: 8'd0, is_end: 1'b1, byte_count: st.bytes_out};
          st_nxt    = kesd_pkg::DEC_STATE_RST;
        end else if ((ch == kesd_pkg::CH_BSLASH) || (ch == kesd_pkg::CH_CARET) ||
                     (ch == kesd_pkg::CH_HASH) || (ch == kesd_pkg::CH_LC_E) ||
                     (ch == kesd_pkg::CH_LC_N) || (ch == kesd_pkg::CH_MINUS)) begin
          res_valid = 1'b1;
          if (ch == kesd_pkg::CH_LC_E) begin
            res.out_byte = kesd_pkg::CH_ESC;
          end else if (ch == kesd_pkg::CH_LC_N) begin
            res.out_byte = kesd_pkg::CH_LF;
          end else if (ch == kesd_pkg::CH_MINUS) begin
            res.out_byte = kesd_pkg::CH_SPACE;
          end else begin
            res.out_byte = ch;
          end
          st_nxt.bytes_out = st.bytes_out + 8'd1;
          st_nxt.mode      = kesd_pkg::MODE_NORMAL;
        end else begin
          st_nxt.digit_value    = 8'd0;
          st_nxt.digits_stopped = 1'b0;
          if ((ch == kesd_pkg::CH_LC_X) || (ch == kesd_pkg::CH_UC_X)) begin
            st_nxt.mode        = kesd_pkg::MODE_HEX;
            st_nxt.digits_left = 2'd2;
          end else if (is_oct) begin
            st_nxt.mode        = kesd_pkg::MODE_OCT;
            st_nxt.digit_value = {5'd0, ch[2:0]};
            st_nxt.digits_left = 2'd2;
          end else begin
            st_nxt.mode = kesd_pkg::MODE_NORMAL;
          end
        end
      end
      kesd_pkg::MODE_HEX, kesd_pkg::MODE_OCT: begin
        if (ch == kesd_pkg::CH_NUL) begin
          res_valid = 1'b1;
          res       = '{out_byte: 8'd0, is_end: 1'b1, byte_count: st.bytes_out};
          st_nxt    = kesd_pkg::DEC_STATE_RST;
        end else begin
          if (!st.digits_stopped) begin
            if (dig_ok) begin
              st_nxt.digit_value = dig_acc;
            end else begin
              st_nxt.digits_stopped = 1'b1;
            end
          end
          st_nxt.digits_left = st.digits_left - 2'd1;
          if (st_nxt.digits_left == 2'd0) begin
            res_valid        = 1'b1;
            res.out_byte     = st_nxt.digit_value;
            st_nxt.bytes_out = st.bytes_out + 8'd1;
            st_nxt.mode      = kesd_pkg::MODE_NORMAL;
          end
        end
      end
      kesd_pkg::MODE_SKIP: begin
        if (ch == kesd_pkg::CH_NUL) begin
          st_nxt.mode = kesd_pkg::MODE_NORMAL;
        end
      end
      kesd_pkg::MODE_NORMAL: begin
        start = 1'b1;
      end
      default: begin
        st_nxt.mode = kesd_pkg::MODE_NORMAL;
        start       = 1'b1;
      end
    endcase

    // new translation unit
    if (start) begin
      if (ch == kesd_pkg::CH_NUL) begin
        res_valid = 1'b1;
        res       = '{out_byte: 8'd0, is_end: 1'b1, byte_count: st.bytes_out};
        st_nxt    = kesd_pkg::DEC_STATE_RST;
      end else if (st.units_used >= unit_limit) begin
        res_valid   = 1'b1;
        res         = '{out_byte: 8'd0, is_end: 1'b1, byte_count: st.bytes_out};
        st_nxt      = kesd_pkg::DEC_STATE_RST;
        st_nxt.mode = kesd_pkg::MODE_SKIP;
      end else begin
        st_nxt.units_used = st.units_used + 8'd1;
        if (ch == kesd_pkg::CH_CARET) begin
          st_nxt.mode = kesd_pkg::MODE_CARET;
        end else if (ch == kesd_pkg::CH_BSLASH) begin
          st_nxt.mode = kesd_pkg::MODE_BSLASH;
        end else begin
          res_valid        = 1'b1;
          res.out_byte     = ch;
          st_nxt.bytes_out = st.bytes_out + 8'd1;
          st_nxt.mode      = kesd_pkg::MODE_NORMAL;
        end
      end
    end
  end

endmodule
